[design/join_and_upload_backoff_controller_assert.svh]
// Assertion macros for the join and upload backoff controller, included by jub_step.sv.
`ifndef JOIN_AND_UPLOAD_BACKOFF_CONTROLLER_ASSERT_SVH
`define JOIN_AND_UPLOAD_BACKOFF_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define JUB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jub assertion failed");
`define JUB_ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("jub assertion failed");
`else
`define JUB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define JUB_ASSERT_HOLDS(label, clk, rst, expr)
`endif

`endif

[design/jub_pkg.sv]
// Types and constants of the join and upload backoff controller.
package jub_pkg;

  typedef enum logic [2:0] {
    MODE_NOT_JOINED = 3'd0,
    MODE_JOINING    = 3'd1,
    MODE_JOINED     = 3'd2,
    MODE_UPLOADING  = 3'd3,
    MODE_DONE       = 3'd4,
    MODE_SLEEP      = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_JOIN_REQ = 3'd1,
    ACT_JOINED   = 3'd2,
    ACT_KEY      = 3'd3,
    ACT_ACK      = 3'd4,
    ACT_EXPIRE   = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_ALLOWED = 3'd1,
    ST_BUSY        = 3'd2,
    ST_IGNORED     = 3'd3,
    ST_RETRIES     = 3'd4,
    ST_TIMEOUT     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    JCMD_NONE   = 2'd0,
    JCMD_JOIN   = 2'd1,
    JCMD_CANCEL = 2'd2
  } jcmd_t;

  typedef enum logic [2:0] {
    REG_JOIN_TIMEOUT   = 3'd0,
    REG_UPLOAD_TIMEOUT = 3'd1,
    REG_DONE_HOLD      = 3'd2,
    REG_MAX_RETRIES    = 3'd3,
    REG_INIT_WINDOW    = 3'd4,
    REG_MAX_WINDOW     = 3'd5,
    REG_SLOT           = 3'd6
  } reg_idx_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [2:0]  KeyUnknownLo = 3'd0;
  localparam logic [2:0]  KeyUnknownHi = 3'd7;

  localparam logic [15:0] JoinTimeoutRst   = 16'd30000;
  localparam logic [15:0] UploadTimeoutRst = 16'd3000;
  localparam logic [10:0] DoneHoldRst      = 11'd1000;
  localparam logic [3:0]  MaxRetriesRst    = 4'd8;
  localparam logic [7:0]  InitWindowRst    = 8'd8;
  localparam logic [7:0]  MaxWindowRst     = 8'd64;
  localparam logic [8:0]  SlotRst          = 9'd1;

  typedef struct packed {
    logic [15:0] join_timeout_ms;
    logic [15:0] upload_timeout_ms;
    logic [10:0] done_hold_ms;
    logic [3:0]  max_retries;
    logic [7:0]  initial_window;
    logic [7:0]  max_window;
    logic [8:0]  slot_ms;
  } cfg_t;

  typedef struct packed {
    mode_t       system_state;
    status_t     status;
    logic        send_upload;
    logic [15:0] sequence_res;
    logic [2:0]  upload_option;
    logic [3:0]  retry_number;
    logic        arm_timer;
    logic [15:0] delay_high_ms;
    jcmd_t       join_command;
  } res_t;

endpackage

[design/jub_if.sv]
// Channel interfaces: event input, result output and register write.
interface jub_in_if import jub_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [2:0] key_number;
  modport source (output valid, action, key_number, input ready);
  modport sink (input valid, action, key_number, output ready);
endinterface

interface jub_out_if import jub_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  system_state;
  logic [2:0]  status;
  logic        send_upload;
  logic [15:0] sequence_res;
  logic [2:0]  upload_option;
  logic [3:0]  retry_number;
  logic        arm_timer;
  logic [15:0] delay_high_ms;
  logic [1:0]  join_command;
  modport source (output valid, system_state, status, send_upload, sequence_res,
                  upload_option, retry_number, arm_timer, delay_high_ms,
                  join_command, input ready);
  modport sink (input valid, system_state, status, send_upload, sequence_res,
                upload_option, retry_number, arm_timer, delay_high_ms,
                join_command, output ready);
endinterface

interface jub_cfg_if import jub_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/join_and_upload_backoff_controller.sv]
// Top level of the join and upload backoff controller.
// Usage:
//   request: one event per transfer (action, key_number). Ticks, join
//     requests, radio-joined indications, key presses, acks and retry
//     timer expiries all come through this channel.
//   result: exactly one result per event, in order: mode after the event,
//     status, upload frame and retry timer commands, join command.
//   cfg: register writes (index, data), always ready; write only while idle.
// An event is taken into the input register, and the state update then loads
// the result register and raises result valid; the result register holds
// its result while the receiver stalls. Throughput is one event per cycle while
// the result receiver keeps ready up, set by the single state update per cycle.
// Reset (rst, synchronous) empties both stages, puts the node in not joined
// with all counters at zero and loads the register defaults.
// When the result receiver stalls, the result register holds its transfer,
// the input register still takes one more event, and then request.ready
// drops until the result is taken.
module join_and_upload_backoff_controller import jub_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  jub_in_if.sink     request,
  jub_out_if.source  result,
  jub_cfg_if.sink    cfg
);

  cfg_t       regs;
  res_t       res;
  res_t       res_q;
  logic       s1_valid;
  logic [2:0] action_q;
  logic [2:0] key_q;
  logic       advance;
  logic       take;
  logic       step_en;

  assign advance       = !result.valid || result.ready;
  assign request.ready = !s1_valid || advance;
  assign take          = request.valid && request.ready;
  assign step_en       = s1_valid && advance;

  jub_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  jub_step u_step (
    .clk        (clk),
    .rst        (rst),
    .en         (step_en),
    .action     (action_q),
    .key_number (key_q),
    .regs       (regs),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !advance);
      if (advance) result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      action_q <= request.action;
      key_q    <= request.key_number;
    end
    if (step_en) res_q <= res;
  end

  assign result.system_state  = res_q.system_state;
  assign result.status        = res_q.status;
  assign result.send_upload   = res_q.send_upload;
  assign result.sequence_res  = res_q.sequence_res;
  assign result.upload_option = res_q.upload_option;
  assign result.retry_number  = res_q.retry_number;
  assign result.arm_timer     = res_q.arm_timer;
  assign result.delay_high_ms = res_q.delay_high_ms;
  assign result.join_command  = res_q.join_command;

endmodule

[design/jub_cfg_regs.sv]
// Configuration register file written through the register channel.
module jub_cfg_regs import jub_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jub_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.join_timeout_ms   <= JoinTimeoutRst;
      regs.upload_timeout_ms <= UploadTimeoutRst;
      regs.done_hold_ms      <= DoneHoldRst;
      regs.max_retries       <= MaxRetriesRst;
      regs.initial_window    <= InitWindowRst;
      regs.max_window        <= MaxWindowRst;
      regs.slot_ms           <= SlotRst;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_JOIN_TIMEOUT:   regs.join_timeout_ms   <= cfg.data;
        REG_UPLOAD_TIMEOUT: regs.upload_timeout_ms <= cfg.data;
        REG_DONE_HOLD:      regs.done_hold_ms      <= cfg.data[10:0];
        REG_MAX_RETRIES:    regs.max_retries       <= cfg.data[3:0];
        REG_INIT_WINDOW:    regs.initial_window    <= cfg.data[7:0];
        REG_MAX_WINDOW:     regs.max_window        <= cfg.data[7:0];
        REG_SLOT:           regs.slot_ms           <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

endmodule

[design/jub_step.sv]
// Node state registers and the per-event update logic.
`include "join_and_upload_backoff_controller_assert.svh"

module jub_step import jub_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [2:0] action,
  input  logic [2:0] key_number,
  input  cfg_t       regs,
  output res_t       res
);

  mode_t       mode, mode_next;
  logic        uploading, uploading_next;
  logic [15:0] upload_seq, upload_seq_next;
  logic [2:0]  held_option, held_option_next;
  logic [3:0]  retries_done, retries_done_next;
  logic [7:0]  window, window_next;
  logic [15:0] join_elapsed, join_elapsed_next;
  logic [15:0] upload_elapsed, upload_elapsed_next;
  logic [10:0] hold_elapsed, hold_elapsed_next;

  status_t     status;
  logic        send, arm;
  jcmd_t       jcmd;
  logic [8:0]  doubled;
  logic [16:0] prod;

  always_comb begin
    mode_next           = mode;
    uploading_next      = uploading;
    upload_seq_next     = upload_seq;
    held_option_next    = held_option;
    retries_done_next   = retries_done;
    window_next         = window;
    join_elapsed_next   = join_elapsed;
    upload_elapsed_next = upload_elapsed;
    hold_elapsed_next   = hold_elapsed;
    status              = ST_OK;
    send                = 1'b0;
    arm                 = 1'b0;
    jcmd                = JCMD_NONE;
    doubled             = {window, 1'b0};
    case (act_t'(action))
      ACT_TICK: begin
        if (mode == MODE_JOINING) begin
          if (join_elapsed != 16'hFFFF) join_elapsed_next = join_elapsed + 16'd1;
          if (join_elapsed_next >= regs.join_timeout_ms) begin
            mode_next = MODE_NOT_JOINED;
            jcmd      = JCMD_CANCEL;
          end
        end
        if (uploading && upload_elapsed != 16'hFFFF) begin
          upload_elapsed_next = upload_elapsed + 16'd1;
        end
        if (mode == MODE_DONE) begin
          if (hold_elapsed != 11'h7FF) hold_elapsed_next = hold_elapsed + 11'd1;
          if (hold_elapsed_next >= regs.done_hold_ms) mode_next = MODE_JOINED;
        end
      end
      ACT_JOIN_REQ: begin
        if (mode == MODE_NOT_JOINED) begin
          mode_next         = MODE_JOINING;
          join_elapsed_next = '0;
          jcmd              = JCMD_JOIN;
        end else begin
          status = ST_NOT_ALLOWED;
        end
      end
      ACT_JOINED: begin
        if (mode == MODE_JOINING) mode_next = MODE_JOINED;
        else status = ST_IGNORED;
      end
      ACT_KEY: begin
        if (key_number == KeyUnknownLo || key_number == KeyUnknownHi) begin
          status = ST_IGNORED;
        end else if (mode != MODE_JOINED && mode != MODE_UPLOADING) begin
          status = ST_NOT_ALLOWED;
        end else if (uploading) begin
          status = ST_BUSY;
        end else begin
          uploading_next      = 1'b1;
          upload_seq_next     = upload_seq + 16'd1;
          held_option_next    = key_number;
          retries_done_next   = '0;
          upload_elapsed_next = '0;
          window_next         = regs.initial_window;
          mode_next           = MODE_UPLOADING;
          send                = 1'b1;
          arm                 = 1'b1;
        end
      end
      ACT_ACK: begin
        if (uploading) begin
          uploading_next    = 1'b0;
          mode_next         = MODE_DONE;
          hold_elapsed_next = '0;
        end else begin
          status = ST_IGNORED;
        end
      end
      ACT_EXPIRE: begin
        if (!uploading || mode != MODE_UPLOADING) begin
          status = ST_IGNORED;
        end else if (retries_done >= regs.max_retries) begin
          uploading_next = 1'b0;
          mode_next      = MODE_JOINED;
          status         = ST_RETRIES;
        end else if (upload_elapsed >= regs.upload_timeout_ms) begin
          uploading_next = 1'b0;
          mode_next      = MODE_JOINED;
          status         = ST_TIMEOUT;
        end else begin
          retries_done_next = retries_done + 4'd1;
          // double the window, capped at max_window
          if (doubled > {1'b0, regs.max_window}) window_next = regs.max_window;
          else window_next = doubled[7:0];
          send = 1'b1;
          arm  = 1'b1;
        end
      end
      default: status = ST_IGNORED;
    endcase
  end

  assign prod = 17'(window_next) * 17'(regs.slot_ms);

  always_comb begin
    res.system_state  = mode_next;
    res.status        = status;
    res.send_upload   = send;
    res.sequence_res  = upload_seq_next;
    res.upload_option = held_option_next;
    res.retry_number  = retries_done_next;
    res.arm_timer     = arm;
    res.join_command  = jcmd;
    if (!arm) res.delay_high_ms = '0;
    else if (prod[16]) res.delay_high_ms = 16'hFFFF;
    else res.delay_high_ms = prod[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NOT_JOINED;
      uploading      <= 1'b0;
      upload_seq     <= '0;
      held_option    <= '0;
      retries_done   <= '0;
      window         <= '0;
      join_elapsed   <= '0;
      upload_elapsed <= '0;
      hold_elapsed   <= '0;
    end else if (en) begin
      mode           <= mode_next;
      uploading      <= uploading_next;
      upload_seq     <= upload_seq_next;
      held_option    <= held_option_next;
      retries_done   <= retries_done_next;
      window         <= window_next;
      join_elapsed   <= join_elapsed_next;
      upload_elapsed <= upload_elapsed_next;
      hold_elapsed   <= hold_elapsed_next;
    end
  end

  // an upload runs exactly while the node sits in the uploading mode
  `JUB_ASSERT_HOLDS(a_upload_mode, clk, rst, uploading == (mode == MODE_UPLOADING))
  `JUB_ASSERT_IMPLY(a_arm_sends, clk, rst, en && res.arm_timer, res.send_upload)
  `JUB_ASSERT_IMPLY(a_delay_idle, clk, rst, en && !res.arm_timer, res.delay_high_ms == 16'd0)
  `JUB_ASSERT_IMPLY(a_send_ok, clk, rst, en && res.send_upload, res.status == ST_OK)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the join and upload backoff controller.
module testbench;
  import jub_pkg::*;

  localparam logic [2:0] ActUndefLo = 3'd6;
  localparam logic [2:0] ActUndefHi = 3'd7;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOffCycles = 80;

  typedef struct {
    logic [2:0] act;
    logic [2:0] key;
    bit         typed;
    res_t       want;
  } drow_t;

  logic clk;
  logic rst;

  jub_in_if  ev_ch ();
  jub_out_if res_ch ();
  jub_cfg_if cfg_ch ();

  join_and_upload_backoff_controller DUT (
    .clk     (clk),
    .rst     (rst),
    .request (ev_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  // predicted node state and register copy
  cfg_t        regs;
  mode_t       node_mode;
  logic        up_active;
  logic [15:0] up_seq;
  logic [2:0]  up_option;
  logic [3:0]  retries;
  logic [7:0]  win;
  logic [15:0] join_ms;
  logic [15:0] up_ms;
  logic [10:0] hold_ms;

  res_t        pending_results[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          squeeze_req = 1'b0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [15:0] window_span();
    int unsigned p;
    p = win * regs.slot_ms;
    return (p > 32'hFFFF) ? 16'hFFFF : 16'(p);
  endfunction

  function automatic res_t advance_node(logic [2:0] act, logic [2:0] key);
    res_t r;
    int unsigned w;
    r = '0;
    r.status = ST_OK;
    r.join_command = JCMD_NONE;
    case (act)
      ACT_TICK: begin
        if (node_mode == MODE_JOINING) begin
          if (join_ms != 16'hFFFF) join_ms++;
          if (join_ms >= regs.join_timeout_ms) begin
            node_mode = MODE_NOT_JOINED;
            r.join_command = JCMD_CANCEL;
          end
        end
        if (up_active && up_ms != 16'hFFFF) up_ms++;
        if (node_mode == MODE_DONE) begin
          if (hold_ms != 11'h7FF) hold_ms++;
          if (hold_ms >= regs.done_hold_ms) node_mode = MODE_JOINED;
        end
      end
      ACT_JOIN_REQ: begin
        if (node_mode == MODE_NOT_JOINED) begin
          node_mode = MODE_JOINING;
          join_ms = '0;
          r.join_command = JCMD_JOIN;
        end else begin
          r.status = ST_NOT_ALLOWED;
        end
      end
      ACT_JOINED: begin
        if (node_mode == MODE_JOINING) node_mode = MODE_JOINED;
        else r.status = ST_IGNORED;
      end
      ACT_KEY: begin
        if (key == KeyUnknownLo || key == KeyUnknownHi) begin
          r.status = ST_IGNORED;
        end else if (node_mode != MODE_JOINED && node_mode != MODE_UPLOADING) begin
          r.status = ST_NOT_ALLOWED;
        end else if (up_active) begin
          r.status = ST_BUSY;
        end else begin
          up_active = 1'b1;
          up_seq = up_seq + 16'd1;
          up_option = key;
          retries = '0;
          up_ms = '0;
          win = regs.initial_window;
          node_mode = MODE_UPLOADING;
          r.send_upload = 1'b1;
          r.arm_timer = 1'b1;
          r.delay_high_ms = window_span();
        end
      end
      ACT_ACK: begin
        if (up_active) begin
          up_active = 1'b0;
          node_mode = MODE_DONE;
          hold_ms = '0;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      ACT_EXPIRE: begin
        if (!up_active || node_mode != MODE_UPLOADING) begin
          r.status = ST_IGNORED;
        end else if (retries >= regs.max_retries) begin
          up_active = 1'b0;
          node_mode = MODE_JOINED;
          r.status = ST_RETRIES;
        end else if (up_ms >= regs.upload_timeout_ms) begin
          up_active = 1'b0;
          node_mode = MODE_JOINED;
          r.status = ST_TIMEOUT;
        end else begin
          // retransmit: window doubles, capped at max_window
          w = win * 2;
          if (w > regs.max_window) w = regs.max_window;
          win = 8'(w);
          retries = retries + 4'd1;
          r.send_upload = 1'b1;
          r.arm_timer = 1'b1;
          r.delay_high_ms = window_span();
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.system_state = node_mode;
    r.sequence_res = up_seq;
    r.upload_option = up_option;
    r.retry_number = retries;
    return r;
  endfunction

  function automatic res_t outcome(mode_t s, status_t st, logic send, logic [15:0] seq,
                                   logic [2:0] opt, logic [3:0] rn, logic arm,
                                   logic [15:0] dly, jcmd_t jc);
    res_t r;
    r.system_state = s;
    r.status = st;
    r.send_upload = send;
    r.sequence_res = seq;
    r.upload_option = opt;
    r.retry_number = rn;
    r.arm_timer = arm;
    r.delay_high_ms = dly;
    r.join_command = jc;
    return r;
  endfunction

  function automatic drow_t row(logic [2:0] act, logic [2:0] key, bit typed, res_t want);
    drow_t d;
    d.act = act;
    d.key = key;
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic offer_event(logic [2:0] act, logic [2:0] key, bit typed, res_t want);
    res_t got;
    while (!steady && $urandom_range(99) < 10) begin
      ev_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.action <= act;
    ev_ch.key_number <= key;
    @(posedge clk);
    while (ev_ch.ready !== 1'b1) @(posedge clk);
    got = advance_node(act, key);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_JOIN_TIMEOUT:   regs.join_timeout_ms = val;
      REG_UPLOAD_TIMEOUT: regs.upload_timeout_ms = val;
      REG_DONE_HOLD:      regs.done_hold_ms = val[10:0];
      REG_MAX_RETRIES:    regs.max_retries = val[3:0];
      REG_INIT_WINDOW:    regs.initial_window = val[7:0];
      REG_MAX_WINDOW:     regs.max_window = val[7:0];
      REG_SLOT:           regs.slot_ms = val[8:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_setting(logic [15:0] jt, logic [15:0] ut, logic [15:0] dh,
                              logic [15:0] mr, logic [15:0] iw, logic [15:0] mw,
                              logic [15:0] sl);
    write_reg(REG_JOIN_TIMEOUT, jt);
    write_reg(REG_UPLOAD_TIMEOUT, ut);
    write_reg(REG_DONE_HOLD, dh);
    write_reg(REG_MAX_RETRIES, mr);
    write_reg(REG_INIT_WINDOW, iw);
    write_reg(REG_MAX_WINDOW, mw);
    write_reg(REG_SLOT, sl);
    cfg_ch.valid <= 1'b0;
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic quiesce();
    ev_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly the event that moves the node forward, some noise
  task automatic choose_event(output logic [2:0] act, output logic [2:0] key);
    int unsigned r;
    r = $urandom_range(99);
    key = 3'($urandom_range(1, 6));
    if (r < 12) begin
      act = 3'($urandom_range(7));
      key = 3'($urandom_range(7));
    end else begin
      case (node_mode)
        MODE_NOT_JOINED: act = (r < 80) ? ACT_JOIN_REQ : ACT_TICK;
        MODE_JOINING:    act = (r < 45) ? ACT_JOINED : ACT_TICK;
        MODE_JOINED:     act = (r < 70) ? ACT_KEY : ACT_TICK;
        MODE_UPLOADING: begin
          if (r < 55) act = ACT_EXPIRE;
          else if (r < 80) act = ACT_TICK;
          else if (r < 92) act = ACT_ACK;
          else act = ACT_KEY;
        end
        default: act = ACT_TICK;
      endcase
    end
  endtask

  task automatic run_random(int unsigned count);
    logic [2:0] a;
    logic [2:0] k;
    repeat (count) begin
      choose_event(a, k);
      offer_event(a, k, 1'b0, '0);
    end
  endtask

  // result receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = HoldOffCycles - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("system_state", want.system_state, res_ch.system_state);
        compare_field("status", want.status, res_ch.status);
        compare_field("send_upload", want.send_upload, res_ch.send_upload);
        compare_field("sequence_res", want.sequence_res, res_ch.sequence_res);
        compare_field("upload_option", want.upload_option, res_ch.upload_option);
        compare_field("retry_number", want.retry_number, res_ch.retry_number);
        compare_field("arm_timer", want.arm_timer, res_ch.arm_timer);
        compare_field("delay_high_ms", want.delay_high_ms, res_ch.delay_high_ms);
        compare_field("join_command", want.join_command, res_ch.join_command);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (ev_ch.valid === 1'b1 && ev_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    drow_t script[$];
    int unsigned p;
    rst = 1'b1;
    ev_ch.valid = 1'b0;
    ev_ch.action = ACT_TICK;
    ev_ch.key_number = KeyUnknownLo;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_JOIN_TIMEOUT;
    cfg_ch.data = '0;
    regs = '{JoinTimeoutRst, UploadTimeoutRst, DoneHoldRst, MaxRetriesRst,
             InitWindowRst, MaxWindowRst, SlotRst};
    node_mode = MODE_NOT_JOINED;
    up_active = 1'b0;
    up_seq = '0;
    up_option = '0;
    retries = '0;
    win = '0;
    join_ms = '0;
    up_ms = '0;
    hold_ms = '0;

    // default registers: walk the node through join, upload, backoff and ack
    script.push_back(row(ACT_TICK, KeyUnknownLo, 1,
      outcome(MODE_NOT_JOINED, ST_OK, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_ACK, KeyUnknownLo, 1,
      outcome(MODE_NOT_JOINED, ST_IGNORED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_EXPIRE, KeyUnknownLo, 1,
      outcome(MODE_NOT_JOINED, ST_IGNORED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_JOINED, KeyUnknownLo, 1,
      outcome(MODE_NOT_JOINED, ST_IGNORED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_KEY, 3'd3, 1,
      outcome(MODE_NOT_JOINED, ST_NOT_ALLOWED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_KEY, KeyUnknownLo, 1,
      outcome(MODE_NOT_JOINED, ST_IGNORED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ActUndefLo, KeyUnknownLo, 1,
      outcome(MODE_NOT_JOINED, ST_IGNORED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ActUndefHi, KeyUnknownHi, 1,
      outcome(MODE_NOT_JOINED, ST_IGNORED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_JOIN_REQ, KeyUnknownLo, 1,
      outcome(MODE_JOINING, ST_OK, 0, 0, 0, 0, 0, 0, JCMD_JOIN)));
    script.push_back(row(ACT_JOIN_REQ, KeyUnknownLo, 1,
      outcome(MODE_JOINING, ST_NOT_ALLOWED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_TICK, KeyUnknownHi, 0, '0));
    script.push_back(row(ACT_JOINED, KeyUnknownLo, 1,
      outcome(MODE_JOINED, ST_OK, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_KEY, KeyUnknownHi, 1,
      outcome(MODE_JOINED, ST_IGNORED, 0, 0, 0, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_KEY, 3'd6, 1,
      outcome(MODE_UPLOADING, ST_OK, 1, 1, 6, 0, 1, 8, JCMD_NONE)));
    script.push_back(row(ACT_KEY, 3'd1, 1,
      outcome(MODE_UPLOADING, ST_BUSY, 0, 1, 6, 0, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_EXPIRE, KeyUnknownLo, 1,
      outcome(MODE_UPLOADING, ST_OK, 1, 1, 6, 1, 1, 16, JCMD_NONE)));
    script.push_back(row(ACT_EXPIRE, KeyUnknownLo, 1,
      outcome(MODE_UPLOADING, ST_OK, 1, 1, 6, 2, 1, 32, JCMD_NONE)));
    script.push_back(row(ACT_EXPIRE, KeyUnknownLo, 1,
      outcome(MODE_UPLOADING, ST_OK, 1, 1, 6, 3, 1, 64, JCMD_NONE)));
    // window reaches max_window and stays there
    script.push_back(row(ACT_EXPIRE, KeyUnknownLo, 1,
      outcome(MODE_UPLOADING, ST_OK, 1, 1, 6, 4, 1, 64, JCMD_NONE)));
    script.push_back(row(ACT_TICK, KeyUnknownLo, 0, '0));
    script.push_back(row(ACT_ACK, KeyUnknownLo, 1,
      outcome(MODE_DONE, ST_OK, 0, 1, 6, 4, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_EXPIRE, KeyUnknownLo, 1,
      outcome(MODE_DONE, ST_IGNORED, 0, 1, 6, 4, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_KEY, 3'd2, 1,
      outcome(MODE_DONE, ST_NOT_ALLOWED, 0, 1, 6, 4, 0, 0, JCMD_NONE)));
    script.push_back(row(ACT_TICK, KeyUnknownLo, 0, '0));
    script.push_back(row(ACT_JOIN_REQ, KeyUnknownLo, 1,
      outcome(MODE_DONE, ST_NOT_ALLOWED, 0, 1, 6, 4, 0, 0, JCMD_NONE)));

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) offer_event(script[i].act, script[i].key, script[i].typed,
                                    script[i].want);
    quiesce();

    // lowest register values: immediate exhaustion, instant join cancel
    load_setting(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
    run_random(110);
    quiesce();

    // highest timeout, hold and retry values; windows of 128 and a slot of 500
    load_setting(16'd65535, 16'd65535, 16'd2047, 16'd15, 16'd128, 16'd128, 16'd500);
    run_random(60);
    quiesce();

    for (p = 0; p < 4; p++) begin
      load_setting(16'($urandom_range(1, 24)), 16'($urandom_range(1, 48)),
                   16'($urandom_range(0, 12)), 16'($urandom_range(0, 15)),
                   16'($urandom_range(1, 128)), 16'($urandom_range(1, 128)),
                   16'($urandom_range(1, 500)));
      steady = (p == 2);
      if (p == 0) squeeze_req = 1'b1;
      run_random(95);
      quiesce();
    end
    steady = 1'b0;

    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/jub_pkg.sv
design/jub_if.sv
design/jub_cfg_regs.sv
design/jub_step.sv
design/join_and_upload_backoff_controller.sv
tb/testbench.sv
